// ===== hw/rtl/fse_pkg.sv =====
`timescale 1ns / 1ps
package fse_pkg;

  // Longest string the block holds.
  localparam int MaxLen   = 16;
  localparam int ByteW    = 8;
  localparam int CfgLenW  = 5;
  localparam int MapW     = 64;
  localparam int MapCnt   = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam int IdxW     = $clog2(MaxLen);
  localparam int EffW     = $clog2(MaxLen + 1);
  localparam int LenW     = (EffW > CfgLenW) ? EffW : CfgLenW;
  localparam int CountCap = (MaxLen < 31) ? MaxLen : 31;

  localparam logic [CfgIdxW-1:0] RegWindowLength = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSkipInvalid  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegValidMap0    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegValidMap1    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegValidMap2    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegValidMap3    = 3'd5;

  localparam logic [CfgLenW-1:0] WindowLengthRst = 5'd8;

  typedef struct packed {
    logic accept;
    logic start_emit;
    logic load_out;
  } fse_cmd_t;

  typedef struct packed {
    logic byte_ok;
    logic emit_needed;
    logic out_space;
    logic at_end;
  } fse_sts_t;

endpackage

// ===== hw/rtl/fse_if.sv =====
`timescale 1ns / 1ps
interface fse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_string;

  modport source (output valid, output out_byte, output last_of_string, input ready);
  modport sink (input valid, input out_byte, input last_of_string, output ready);
endinterface

// ===== hw/rtl/fixed_length_string_extractor_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Payload                    Handshake
// in_ch     sink       data_byte[7:0]             valid / ready
// out_ch    source     out_byte[7:0], last_of_string  valid / ready
// cfg       write      cfg_idx_i[2:0], cfg_wdata_i[63:0]  cfg_we_i
//
// An invalid byte passes StIdle only, a valid byte that emits nothing
// StIdle and StCheck; one that emits a string goes on to StEmit and loads
// L bytes (L = window length, 1 to 16), one a cycle to the output register.
// The next byte is taken as soon as the final byte of a string is in the
// output register; a stalled sink holds the emission loop.
// Reset is asynchronous and active low; no clearing pass is needed.
module fixed_length_string_extractor_top import fse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  fse_in_if.sink              in_ch,
  fse_out_if.source           out_ch
);

  fse_cmd_t cmd;
  fse_sts_t sts;

  fse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fse_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .data_byte_i      (in_ch.data_byte),
    .out_ready_i      (out_ch.ready),
    .out_valid_o      (out_ch.valid),
    .out_byte_o       (out_ch.out_byte),
    .last_of_string_o (out_ch.last_of_string),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  // Input transactions and output loads never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |-> !cmd.load_out)
    else $error("input accepted during emission");

  // Once a string starts, no input is taken in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_emit |=> !in_ch.ready)
    else $error("input ready right after string start");

  // The final byte of a string ends the loads.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && sts.at_end) |=> !cmd.load_out)
    else $error("load after final byte");

  // A loaded byte is always presented on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_ch.valid)
    else $error("loaded byte not presented");

endmodule

// ===== hw/rtl/fse_ctrl.sv =====
`timescale 1ns / 1ps
module fse_ctrl import fse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  fse_sts_t sts_i,
  output fse_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StEmit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    in_ready_o       = (state_q == StIdle);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // An invalid byte only touches the run count and causes no result.
          if (sts_i.byte_ok) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (sts_i.emit_needed) begin
          cmd_o.start_emit = 1'b1;
          state_d          = StEmit;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (sts_i.out_space) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.at_end) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/fse_dp.sv =====
`timescale 1ns / 1ps
module fse_dp import fse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [ByteW-1:0]    data_byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [ByteW-1:0]    out_byte_o,
  output logic                last_of_string_o,
  input  fse_cmd_t            cmd_i,
  output fse_sts_t            sts_o
);

  logic [CfgLenW-1:0]          wl_q;
  logic                        skip_q;
  logic [MapCnt-1:0][MapW-1:0] map_q;

  logic [ByteW-1:0] win_q  [MaxLen];
  logic [ByteW-1:0] prev_q [MaxLen];
  logic [LenW-1:0]  count_q;
  logic             present_q;
  logic [IdxW-1:0]  rd_ptr_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             last_q;

  logic [LenW-1:0] wl_wide;
  logic [LenW-1:0] eff_len;
  logic [LenW-1:0] start_wide;
  logic [IdxW-1:0] start_idx;
  logic            differ;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= WindowLengthRst;
      skip_q <= 1'b0;
      map_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWindowLength: wl_q     <= cfg_wdata_i[CfgLenW-1:0];
        RegSkipInvalid:  skip_q   <= cfg_wdata_i[0];
        RegValidMap0:    map_q[0] <= cfg_wdata_i[MapW-1:0];
        RegValidMap1:    map_q[1] <= cfg_wdata_i[MapW-1:0];
        RegValidMap2:    map_q[2] <= cfg_wdata_i[MapW-1:0];
        RegValidMap3:    map_q[3] <= cfg_wdata_i[MapW-1:0];
        default: ;
      endcase
    end
  end

  // A zero length acts as one, anything above the window size as the full window.
  always_comb begin
    wl_wide = LenW'(wl_q);
    if (wl_wide == '0) begin
      eff_len = LenW'(1);
    end else if (wl_wide > LenW'(MaxLen)) begin
      eff_len = LenW'(MaxLen);
    end else begin
      eff_len = wl_wide;
    end
    start_wide = LenW'(MaxLen) - eff_len;
    start_idx  = start_wide[IdxW-1:0];
  end

  always_comb begin
    differ = 1'b0;
    for (int i = 0; i < MaxLen; i++) begin
      if ((IdxW'(i) >= start_idx) && (prev_q[i] != win_q[i])) begin
        differ = 1'b1;
      end
    end
  end

  assign sts_o.byte_ok     = map_q[data_byte_i[7:6]][data_byte_i[5:0]];
  assign sts_o.emit_needed = (count_q >= eff_len) && (!present_q || differ);
  assign sts_o.out_space   = !out_valid_q || out_ready_i;
  assign sts_o.at_end      = (rd_ptr_q == IdxW'(MaxLen - 1));

  // Window shift line; it starts from all zeros so that a later, longer window
  // compares against known bytes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLen; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.accept && sts_o.byte_ok) begin
      for (int i = 0; i < MaxLen - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[MaxLen-1] <= data_byte_i;
    end
  end

  // Copy of the last emitted string.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_emit) begin
      for (int i = 0; i < MaxLen; i++) begin
        prev_q[i] <= win_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      present_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (sts_o.byte_ok) begin
          if (count_q < LenW'(CountCap)) begin
            count_q <= count_q + LenW'(1);
          end
        end else if (!skip_q) begin
          count_q <= '0;
        end
      end
      if (cmd_i.start_emit) begin
        present_q <= 1'b1;
      end
    end
  end

  // The read pointer runs from the oldest byte of the string to the newest.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_emit) begin
      rd_ptr_q <= start_idx;
    end else if (cmd_i.load_out) begin
      rd_ptr_q <= rd_ptr_q + IdxW'(1);
    end
    if (cmd_i.load_out) begin
      out_byte_q <= win_q[rd_ptr_q];
      last_q     <= sts_o.at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign last_of_string_o = last_q;

endmodule

// ===== dv/fixed_length_string_extractor_top_tb.sv =====
`timescale 1ns / 1ps
module fixed_length_string_extractor_top_tb;
  import fse_pkg::*;

  // Indexes beyond the last register: the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam int SettleCycles = 32;
  localparam int StallLimit   = 2000;
  localparam int SubPhases    = 6;
  localparam int BytesPerSub  = 18;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last_of_string;
  } str_char_t;

  typedef logic [MapCnt-1:0][MapW-1:0] char_map_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  fse_in_if  in_if ();
  fse_out_if out_if ();

  fixed_length_string_extractor_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state and its copy of the registers.
  logic [ByteW-1:0]   win_bytes [MaxLen];
  logic [ByteW-1:0]   prev_str  [MaxLen];
  logic               prev_valid;
  int                 run_len;
  logic [CfgLenW-1:0] cfg_len;
  logic               cfg_skip;
  char_map_t          char_map;

  str_char_t expected_chars [$];

  int errors;
  int bytes_sent;
  int chars_seen;
  int strings_seen;
  int configs_applied;
  int src_idle_pct;
  int snk_idle_pct;

  function automatic void predict_strings(input logic [ByteW-1:0] b);
    int        span;
    bit        same_as_prev;
    str_char_t c;
    span = (cfg_len == 0) ? 1 : ((cfg_len > MaxLen) ? MaxLen : int'(cfg_len));
    if (!char_map[b[7:6]][b[5:0]]) begin
      if (!cfg_skip) run_len = 0;
      return;
    end
    for (int i = 0; i < MaxLen - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[MaxLen - 1] = b;
    if (run_len < CountCap) run_len++;
    if (run_len < span) return;
    // Only the tail of the stored string that the current length covers counts.
    same_as_prev = prev_valid;
    for (int i = MaxLen - span; i < MaxLen; i++) begin
      if (prev_str[i] != win_bytes[i]) same_as_prev = 1'b0;
    end
    if (same_as_prev) return;
    for (int i = MaxLen - span; i < MaxLen; i++) begin
      c.out_byte       = win_bytes[i];
      c.last_of_string = (i == MaxLen - 1);
      expected_chars.push_back(c);
    end
    prev_str   = win_bytes;
    prev_valid = 1'b1;
  endfunction

  function automatic char_map_t range_map(input int lo, input int hi);
    char_map_t m;
    m = '0;
    for (int v = lo; v <= hi; v++) m[v / MapW][v % MapW] = 1'b1;
    return m;
  endfunction

  function automatic char_map_t random_map();
    char_map_t m;
    m = '0;
    case ($urandom_range(0, 3))
      0: m = range_map(8'h20, 8'h7e);
      1: for (int i = 0; i < MapCnt; i++) m[i] = {$urandom, $urandom};
      2: m = '1;
      default: begin
        repeat (4) m[$urandom_range(0, MapCnt - 1)][$urandom_range(0, MapW - 1)] = 1'b1;
      end
    endcase
    return m;
  endfunction

  // Draws a byte of the wanted class under the current map, if one exists.
  function automatic logic [ByteW-1:0] pick_byte(input bit want_valid);
    logic [ByteW-1:0] b;
    b = '0;
    for (int t = 0; t < 512; t++) begin
      b = ByteW'($urandom_range(0, 255));
      if (char_map[b[7:6]][b[5:0]] == want_valid) return b;
    end
    return b;
  endfunction

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegWindowLength: cfg_len     = data[CfgLenW-1:0];
      RegSkipInvalid:  cfg_skip    = data[0];
      RegValidMap0:    char_map[0] = data;
      RegValidMap1:    char_map[1] = data;
      RegValidMap2:    char_map[2] = data;
      RegValidMap3:    char_map[3] = data;
      default: ;
    endcase
  endtask

  // Registers change only once every string has left and the block is quiet.
  task automatic settle_block();
    in_if.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CfgLenW-1:0] len, input logic skip,
                            input char_map_t m);
    logic [CfgDataW-1:0] word;
    settle_block();
    word = {$urandom, $urandom};
    word[CfgLenW-1:0] = len;
    cfg_write(RegWindowLength, word);
    word = {$urandom, $urandom};
    word[0] = skip;
    cfg_write(RegSkipInvalid, word);
    cfg_write(RegValidMap0, m[0]);
    cfg_write(RegValidMap1, m[1]);
    cfg_write(RegValidMap2, m[2]);
    cfg_write(RegValidMap3, m[3]);
    if ($urandom_range(0, 3) == 0) begin
      cfg_write(($urandom_range(0, 1) != 0) ? RegSpareLo : RegSpareHi, {$urandom, $urandom});
    end
    cfg_we_i <= 1'b0;
    configs_applied++;
  endtask

  // Valid stays high between back-to-back transactions; it drops only for a gap.
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    do begin
      @(posedge clk_i);
    end while (!in_if.ready);
    predict_strings(b);
    bytes_sent++;
  endtask

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin : check_output
    str_char_t want;
    if (out_if.valid && out_if.ready) begin
      chars_seen++;
      if (out_if.last_of_string) strings_seen++;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected string byte, expected none, actual %02h last %0b",
                 $time, out_if.out_byte, out_if.last_of_string);
      end else begin
        want = expected_chars.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          errors++;
          $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                   $time, want.out_byte, out_if.out_byte);
        end
        if (out_if.last_of_string !== want.last_of_string) begin
          errors++;
          $display("%0t: last_of_string mismatch, expected %0b, actual %0b",
                   $time, want.last_of_string, out_if.last_of_string);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no transaction for %0d cycles, %0d string bytes outstanding",
             $time, StallLimit, expected_chars.size());
    $display("fixed_length_string_extractor_top regression: fail");
    $finish;
  end

  // With every map bit clear nothing is valid; then the reset length of eight applies.
  task automatic test_reset_state();
    send_byte(8'h41);
    send_byte(8'hff);
    settle_block();
    cfg_write(RegValidMap0, '1);
    cfg_write(RegValidMap1, '1);
    cfg_write(RegValidMap2, '1);
    cfg_write(RegValidMap3, '1);
    cfg_write(RegSpareLo, '1);
    cfg_write(RegSpareHi, '1);
    cfg_we_i <= 1'b0;
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7f);
    send_byte(8'hfe);
  endtask

  // A length of zero behaves as one; a repeat is suppressed even across a break.
  task automatic test_duplicates_and_breaks();
    set_config(5'd0, 1'b0, range_map(8'h20, 8'h7e));
    send_byte(8'h41);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'h41);
    send_byte(8'h42);
  endtask

  // Lengthening the window keeps the run, and skipped bytes leave it untouched.
  task automatic test_skip_and_resize();
    set_config(5'd3, 1'b1, range_map(8'h20, 8'h7e));
    send_byte(8'h43);
    send_byte(8'h01);
    send_byte(8'h44);
    send_byte(8'h7f);
  endtask

  task automatic test_random_traffic();
    logic [ByteW-1:0]   alphabet [2];
    logic [CfgLenW-1:0] len;
    int                 style;
    int                 r;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 22;
          snk_idle_pct = 56;
        end
        1: begin
          src_idle_pct = 56;
          snk_idle_pct = 22;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < SubPhases; s++) begin
        if (s == 0) begin
          len = (p == 0) ? 5'd16 : ((p == 1) ? 5'd31 : 5'd1);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 60) len = CfgLenW'($urandom_range(1, 6));
          else if (r < 85) len = CfgLenW'($urandom_range(7, 16));
          else if (r < 92) len = '0;
          else len = CfgLenW'($urandom_range(17, 31));
        end
        set_config(len, 1'($urandom_range(0, 1)), random_map());
        // Mostly runs of valid bytes; a small alphabet makes repeated strings likely.
        style = $urandom_range(0, 9);
        alphabet[0] = pick_byte(1'b1);
        alphabet[1] = pick_byte(1'b1);
        for (int n = 0; n < BytesPerSub; n++) begin
          if (style >= 8) send_byte(ByteW'($urandom_range(0, 255)));
          else if ($urandom_range(0, 99) < 8) send_byte(pick_byte(1'b0));
          else if (style >= 5) send_byte(alphabet[$urandom_range(0, 1)]);
          else send_byte(pick_byte(1'b1));
        end
      end
    end
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= RegWindowLength;
    cfg_wdata_i     <= '0;
    rst_ni          <= 1'b0;
    for (int i = 0; i < MaxLen; i++) begin
      win_bytes[i] = '0;
      prev_str[i]  = '0;
    end
    prev_valid      = 1'b0;
    run_len         = 0;
    cfg_len         = WindowLengthRst;
    cfg_skip        = 1'b0;
    char_map        = '0;
    errors          = 0;
    bytes_sent      = 0;
    chars_seen      = 0;
    strings_seen    = 0;
    configs_applied = 0;
    src_idle_pct    = 22;
    snk_idle_pct    = 56;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_duplicates_and_breaks();
    test_skip_and_resize();
    test_random_traffic();
    settle_block();

    $display("Sent %0d bytes under %0d register settings, window lengths 0 to 31, both modes.",
             bytes_sent, configs_applied);
    $display("Checked %0d string bytes in %0d strings; %0d mismatches, %0d left waiting.",
             chars_seen, strings_seen, errors, expected_chars.size());
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("fixed_length_string_extractor_top regression: pass");
    end else begin
      $display("fixed_length_string_extractor_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fse_pkg.sv
hw/rtl/fse_if.sv
hw/rtl/fse_ctrl.sv
hw/rtl/fse_dp.sv
hw/rtl/fixed_length_string_extractor_top.sv
dv/fixed_length_string_extractor_top_tb.sv
